// ----- hw/rtl/prime_sum_trial_division_defines.svh -----
// Assertion macros shared by the checker of the prime sum block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef PRIME_SUM_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_SUM_TRIAL_DIVISION_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prime sum check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSTD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prime sum check failed");

`endif

// ----- hw/rtl/pstd_pkg.sv -----
// Package for the prime sum block: widths, sequencer states and the saturating add.
// Used by prime_sum_trial_division and its checker; depends on nothing else.
package pstd_pkg;

	localparam int VAL_W = 32;
	localparam int MAG_W = VAL_W - 1;
	localparam int SUM_W = 48;
	localparam int DIV_W = 17;
	localparam int SQ_W = 2 * DIV_W;
	localparam int CNT_W = $clog2(MAG_W);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [MAG_W-1:0] b);
		logic [SUM_W:0] t;
		t = {1'b0, a} + {{(SUM_W + 1 - MAG_W){1'b0}}, b};
		sat_add = t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/prime_sum_trial_division.sv -----
// Prime sum by trial division, with one bit-serial remainder unit shared by all divisors.
// Trial divisors run from 2 upward, at most 46339 of them, until one divides the value or its square exceeds it.
// Each divisor costs one bound check plus 31 restoring-division steps of the remainder unit.
// One item is in work at a time; a new transfer is taken only once the last result has been loaded.
// Reset (arst_n low) clears the sequencer, the output valid and the running total at once.
module prime_sum_trial_division (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [pstd_pkg::VAL_W-1:0] value,
	input  logic                      last,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      value_is_prime,
	output logic [pstd_pkg::SUM_W-1:0] running_sum,
	output logic                      end_of_list
);
	import pstd_pkg::*;

	state_t state_q, state_next;

	logic [MAG_W-1:0] n_q;
	logic             last_q;
	logic             prime_q;
	logic [DIV_W-1:0] d_q;
	logic [SQ_W-1:0]  sq_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] total_q;

	logic             out_valid_q;
	logic             prime_out_q;
	logic [SUM_W-1:0] sum_out_q;
	logic             eol_out_q;

	logic             trivial;
	logic             above_bound;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   d_ext;
	logic             ge;
	logic [DIV_W-1:0] rem_next;
	logic             load_out;
	logic [SUM_W-1:0] sum_next;

	assign trivial = value[VAL_W-1] || (value[MAG_W-1:0] <= MAG_W'(1));
	assign above_bound = sq_q > {{(SQ_W - MAG_W){1'b0}}, n_q};
	assign shifted = {rem_q, n_q[cnt_q]};
	assign d_ext = {1'b0, d_q};
	assign ge = shifted >= d_ext;
	assign rem_next = ge ? DIV_W'(shifted - d_ext) : shifted[DIV_W-1:0];
	assign sum_next = prime_q ? sat_add(total_q, n_q) : total_q;

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		load_out = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = trivial ? ST_FINISH : ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_next = above_bound ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(0)) begin
					state_next = (rem_next == DIV_W'(0)) ? ST_FINISH : ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			total_q <= '0;
		end else begin
			state_q <= state_next;
			if (load_out) begin
				out_valid_q <= 1'b1;
				total_q <= last_q ? '0 : sum_next;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_q <= value[MAG_W-1:0];
					last_q <= last;
					prime_q <= !trivial;
					d_q <= DIV_W'(2);
					sq_q <= SQ_W'(4);
				end
			end
			ST_CHECK: begin
				rem_q <= '0;
				cnt_q <= CNT_W'(MAG_W - 1);
			end
			ST_DIV: begin
				rem_q <= rem_next;
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(0)) begin
					if (rem_next == DIV_W'(0)) begin
						prime_q <= 1'b0;
					end else begin
						d_q <= d_q + DIV_W'(1);
						sq_q <= sq_q + {{(SQ_W - DIV_W - 1){1'b0}}, d_q, 1'b1};
					end
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					prime_out_q <= prime_q;
					sum_out_q <= sum_next;
					eol_out_q <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign value_is_prime = prime_out_q;
	assign running_sum = sum_out_q;
	assign end_of_list = eol_out_q;

endmodule

// ----- hw/rtl/pstd_checker.sv -----
// Port-level checker for prime_sum_trial_division, bound to every instance of it.
// Depends on pstd_pkg and the assertion macros in prime_sum_trial_division_defines.svh.
`include "prime_sum_trial_division_defines.svh"

module pstd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       value_is_prime,
	input logic [pstd_pkg::SUM_W-1:0] running_sum
);
	import pstd_pkg::*;

	// A stalled result stays offered.
	`PSTD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// The block is busy in the cycle after it takes a transfer.
	`PSTD_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// A new result only appears right after the block was busy with its item.
	`PSTD_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))
	// A prime result always carries a nonzero total.
	`PSTD_ASSERT_NOW(a_prime_sum_nonzero, out_valid && value_is_prime,
		running_sum != {SUM_W{1'b0}})

endmodule

bind prime_sum_trial_division pstd_checker u_pstd_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Regression bench for prime_sum_trial_division: a directed table of list elements, then random
// lists sent in bursts while the result side stalls on its own pattern. Imports only pstd_pkg.
// Each result is checked against a trial-division predictor with its own running total, or against the typed row.
module tb_top;
	import pstd_pkg::*;

	localparam int IDLE_LIMIT = 10_000_000;
	localparam int RANDOM_ITEMS = 270;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic             is_prime;
		logic [SUM_W-1:0] total;
		logic             eol;
	} list_result_t;

	typedef struct packed {
		logic [VAL_W-1:0] element;
		logic             eol;
		logic             typed;
		logic             is_prime;
		logic [SUM_W-1:0] total;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [VAL_W-1:0] value = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic value_is_prime;
	logic [SUM_W-1:0] running_sum;
	logic end_of_list;

	list_result_t expected_results[$];
	logic [SUM_W-1:0] model_total = '0;
	int fail_count = 0;
	int idle_cycles = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	table_row_t directed_rows [18] = '{
		'{32'd0,         1'b0, 1'b1, 1'b0, 48'd0},
		'{32'd1,         1'b0, 1'b1, 1'b0, 48'd0},
		'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 48'd0},
		'{32'h8000_0000, 1'b0, 1'b1, 1'b0, 48'd0},
		'{32'd2,         1'b0, 1'b1, 1'b1, 48'd2},
		'{32'd3,         1'b0, 1'b1, 1'b1, 48'd5},
		'{32'd4,         1'b0, 1'b1, 1'b0, 48'd5},
		'{32'h7FFF_FFFE, 1'b0, 1'b1, 1'b0, 48'd5},
		'{32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1, 48'd2147483652},
		'{32'd25,        1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd49,        1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd121,       1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd169,       1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd97,        1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd7919,      1'b0, 1'b0, 1'b0, 48'd0},
		'{32'd1000003,   1'b0, 1'b0, 1'b0, 48'd0},
		'{32'hFFFF_FFF9, 1'b1, 1'b0, 1'b0, 48'd0},
		'{32'd5,         1'b1, 1'b0, 1'b0, 48'd0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	prime_sum_trial_division i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.value         (value),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value_is_prime(value_is_prime),
		.running_sum   (running_sum),
		.end_of_list   (end_of_list)
	);

	function automatic logic trial_division_prime(input logic [VAL_W-1:0] v);
		longint unsigned n;
		longint unsigned d;
		if (v[VAL_W-1])
			return 1'b0;
		n = v;
		if (n <= 1)
			return 1'b0;
		for (d = 2; d * d <= n; d++)
			if (n % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic list_result_t predict_list_step(input logic [VAL_W-1:0] v,
			input logic eol);
		list_result_t r;
		logic [SUM_W:0] t;
		r.is_prime = trial_division_prime(v);
		if (r.is_prime) begin
			t = {1'b0, model_total} + v;
			model_total = t[SUM_W] ? '1 : t[SUM_W-1:0];
		end
		r.total = model_total;
		r.eol = eol;
		if (eol)
			model_total = '0;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] random_element();
		logic [VAL_W-1:0] v;
		int unsigned pick;
		int unsigned factor;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			v = $urandom_range(0, 4000);
		else if (pick < 60)
			v = $urandom_range(4001, 70000);
		else if (pick < 75) begin
			v = $urandom();
			v[VAL_W-1] = 1'b1;
		end else begin
			factor = $urandom_range(2, 7);
			v = $urandom();
			v[VAL_W-1] = 1'b0;
			v = v - v % factor;
		end
		return v;
	endfunction

	task automatic transfer_element(input logic [VAL_W-1:0] v, input logic eol,
			input logic typed, input list_result_t typed_r);
		list_result_t r;
		in_valid <= 1'b1;
		value <= v;
		last <= eol;
		do
			@(posedge clk);
		while (in_stall);
		r = predict_list_step(v, eol);
		expected_results.push_back(typed ? typed_r : r);
	endtask

	task automatic sender_pause(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : result_check
		list_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: value_is_prime %0b running_sum %0d end_of_list %0b",
					value_is_prime, running_sum, end_of_list);
				fail_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (value_is_prime !== exp_r.is_prime) begin
					$error("value_is_prime: expected %0b, got %0b", exp_r.is_prime,
						value_is_prime);
					fail_count++;
				end
				if (running_sum !== exp_r.total) begin
					$error("running_sum: expected %0d, got %0d", exp_r.total, running_sum);
					fail_count++;
				end
				if (end_of_list !== exp_r.eol) begin
					$error("end_of_list: expected %0b, got %0b", exp_r.eol, end_of_list);
					fail_count++;
				end
			end
		end
		if (stall_phase == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_phase <= $urandom_range(8, 64);
		end else
			stall_phase <= stall_phase - 1;
		out_stall <= (stall_mode != 0) && ($urandom_range(0, 3) < stall_mode);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("prime_sum_trial_division regression: fail");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		list_result_t typed_r;
		int burst_left;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i]) begin
			typed_r = '{directed_rows[i].is_prime, directed_rows[i].total, directed_rows[i].eol};
			transfer_element(directed_rows[i].element, directed_rows[i].eol,
				directed_rows[i].typed, typed_r);
			sender_pause($urandom_range(0, 2));
		end
		sender_pause(1);
		while (expected_results.size() != 0)
			@(posedge clk);
		burst_left = 0;
		repeat (RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0)
					sender_pause($urandom_range(1, 12));
				burst_left = $urandom_range(1, 10);
			end
			transfer_element(random_element(), $urandom_range(0, 7) == 0, 1'b0, '0);
			burst_left--;
		end
		sender_pause(1);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0)
			$display("prime_sum_trial_division regression: pass");
		else
			$display("prime_sum_trial_division regression: fail");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pstd_pkg.sv
hw/rtl/prime_sum_trial_division.sv
hw/rtl/pstd_checker.sv
dv/tb_top.sv
